// File: rtl/core/polyphonic_phase_accumulator_synth_core_macros.svh
// assertion helpers, sampled on clk_i and quiet while rst_ni is low
`ifndef POLYPHONIC_PHASE_ACCUMULATOR_SYNTH_CORE_MACROS_SVH
`define POLYPHONIC_PHASE_ACCUMULATOR_SYNTH_CORE_MACROS_SVH

// same-cycle implication
`define PPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ppa_pkg.sv
package ppa_pkg;

  localparam int VOICES     = 12;
  localparam int KEYS       = 12;
  localparam int ECHO_DEPTH = 45;
  localparam int TAP_A      = 44;
  localparam int TAP_B      = 34;
  localparam int TAP_C      = 19;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [17:0] PHASE_GAIN = 18'd195225;
  localparam logic [31:0] RECIP_10   = 32'hCCCCCCCD;
  localparam logic [16:0] GAIN_A     = 17'd45875;
  localparam logic [16:0] GAIN_B     = 17'd32768;
  localparam logic [16:0] GAIN_C     = 17'd13107;
  localparam logic [3:0]  MAX_ROW    = 4'd9;
  localparam logic [4:0]  MAX_VOL    = 5'd16;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_KEYS = 1'b1;

  typedef enum logic [2:0] {
    CFG_VOLUME,
    CFG_OCTAVE,
    CFG_SHAPE,
    CFG_FILTER,
    CFG_CUTOFF,
    CFG_ECHO
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SAW,
    WAVE_TRI,
    WAVE_SQUARE
  } wave_e;

  typedef enum logic [1:0] {
    FILT_NONE,
    FILT_LOW,
    FILT_HIGH
  } filt_e;

  typedef struct packed {
    logic       load_mask;
    logic       scan_valid;
    logic [3:0] scan_idx;
    logic       start_tick;
    logic       issue_valid;
    logic [3:0] issue_idx;
    logic       shape_en;
    logic       echo_en;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic       func;
    logic       keys_differ;
    logic       shape_unused;
    logic [3:0] voice_count;
    logic       mask_bit;
    logic       pipe_busy;
    logic       out_free;
  } status_t;

  function automatic logic [8:0] note_step(input logic [3:0] key);
    logic [8:0] r;
    case (key)
      4'd0:    r = 9'd262;
      4'd1:    r = 9'd277;
      4'd2:    r = 9'd294;
      4'd3:    r = 9'd311;
      4'd4:    r = 9'd330;
      4'd5:    r = 9'd349;
      4'd6:    r = 9'd370;
      4'd7:    r = 9'd392;
      4'd8:    r = 9'd415;
      4'd9:    r = 9'd440;
      4'd10:   r = 9'd466;
      4'd11:   r = 9'd494;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] clamp_weight(input logic signed [5:0] w);
    logic [3:0] r;
    if (w < 6'sd1) begin
      r = 4'd1;
    end else if (w > 6'sd10) begin
      r = 4'd10;
    end else begin
      r = w[3:0];
    end
    return r;
  endfunction

  // low-pass row r rolls off above key 8 - r
  function automatic logic [3:0] lp_weight(input logic [3:0] row, input logic [3:0] key);
    logic signed [5:0] w;
    w = 6'sd18 - $signed({2'b00, row}) - $signed({2'b00, key});
    return clamp_weight(w);
  endfunction

  function automatic logic [3:0] hp_weight(input logic [3:0] row, input logic [3:0] key);
    logic signed [5:0] w;
    w = 6'sd7 - $signed({2'b00, row}) + $signed({2'b00, key});
    return clamp_weight(w);
  endfunction

endpackage

// File: rtl/core/ppa_if.sv
interface ppa_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [11:0] keys_n;

  modport source (output valid, output func, output keys_n, input ready);
  modport sink   (input valid, input func, input keys_n, output ready);
endinterface

interface ppa_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/core/polyphonic_phase_accumulator_synth_core.sv
// Polyphonic phase-accumulator synthesizer core.
// in_if carries one beat per item: func low is a sample tick, func high a key mask
// update with keys_n active low. out_if returns one sample_out beat per tick that runs.
// cfg_we_i/cfg_idx_i/cfg_data_i write the six settings registers; write only while idle.
// A key update whose mask differs from the last one rebuilds the voice list, one scan
// step per key; an unchanged mask is taken without a scan.
// A tick walks its N listed voices through the voice pipe (step multiply, divide-by-ten
// multiply, phase add), issuing one voice per cycle, then through shaping, the echo
// multiplies and the final mix; a tick taken while shape holds the unused code does not run.
// One item is worked at a time; ready is high only between items.
// The result sits in an output register; a stalled receiver holds the block in
// its last step until the register frees, while the waiting beat stays stable.
// Reset clears phases, the echo line, the key history and loads default settings.
module polyphonic_phase_accumulator_synth_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ppa_in_if.sink                        in_if,
  ppa_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppa_pkg::CFG_W-1:0]     cfg_data_i
);
  import ppa_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_if.ready = in_ready;

  ppa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (in_if.func),
    .keys_n_i     (in_if.keys_n),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .sample_out_o (out_if.sample_out)
  );

endmodule

// File: rtl/core/ppa_dp.sv
module ppa_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppa_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        func_i,
  input  logic [11:0]                 keys_n_i,
  input  ppa_pkg::cmd_t               cmd_i,
  output ppa_pkg::status_t            status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [14:0]          sample_out_o
);
  import ppa_pkg::*;

  logic [4:0] vol_q;
  logic [3:0] oct_q;
  logic [1:0] shape_q;
  logic [1:0] filt_q;
  logic [3:0] cutoff_q;
  logic       echo_q;

  logic [11:0] last_keys_q;
  logic [11:0] mask_q;
  logic [3:0]  count_q;
  logic [3:0]  voice_key_q [VOICES];
  logic [31:0] phase_q [VOICES];

  logic        s1_vld_q, s2_vld_q;
  logic [3:0]  s1_idx_q, s2_idx_q;
  logic [3:0]  s1_key_q;
  logic [31:0] s1_inc_q, s2_inc_q;
  logic [3:0]  s2_w_q;
  logic        s2_filt_q;

  logic signed [11:0] sum_q;
  logic signed [15:0] y_q;
  logic signed [15:0] echo_line_q [ECHO_DEPTH];
  logic signed [33:0] pa_q, pb_q, pc_q;
  logic signed [14:0] out_q;
  logic               out_valid_q;

  // voice pipe, first stage
  logic [3:0]  key1;
  logic [19:0] base1, step1;
  logic [37:0] prod1;

  always_comb begin
    key1  = voice_key_q[cmd_i.issue_idx];
    base1 = 20'(note_step(key1));
    if (oct_q < 4'd4) begin
      step1 = base1 >> (4'd4 - oct_q);
    end else begin
      step1 = base1 << (oct_q - 4'd4);
    end
    prod1 = 38'(step1) * 38'(PHASE_GAIN);
  end

  // second stage: divide by ten through the reciprocal
  logic [63:0] prod2;
  logic [3:0]  row2;
  logic [3:0]  w2;

  always_comb begin
    prod2 = 64'(s1_inc_q) * 64'(RECIP_10);
    row2  = (cutoff_q > MAX_ROW) ? MAX_ROW : cutoff_q;
    w2    = (filt_q == 2'(FILT_LOW)) ? lp_weight(row2, s1_key_q) : hp_weight(row2, s1_key_q);
  end

  // third stage: phase update and sum
  logic [35:0] prod3;
  logic [31:0] inc3, phase3;
  logic signed [11:0] sum3;

  always_comb begin
    prod3  = 36'(s2_inc_q) * 36'(s2_w_q);
    inc3   = s2_filt_q ? prod3[31:0] : s2_inc_q;
    phase3 = phase_q[s2_idx_q] + inc3;
    sum3   = sum_q + {{4{phase3[31]}}, phase3[31:24]};
  end

  // shaping
  logic [4:0]         vol_c;
  logic [3:0]         shamt;
  logic signed [11:0] scaled;
  logic signed [15:0] sc16, y_c;
  localparam logic signed [15:0] SQ_HI = 16'sd127;
  localparam logic signed [15:0] SQ_LO = -16'sd128;

  always_comb begin
    vol_c  = (vol_q > MAX_VOL) ? MAX_VOL : vol_q;
    shamt  = 4'd8 - vol_c[4:1];
    scaled = sum_q >>> shamt;
    sc16   = {{4{scaled[11]}}, scaled};
    case (wave_e'(shape_q))
      WAVE_TRI: begin
        y_c = (sum_q < 0) ? 16'sd128 + (sc16 <<< 2) : 16'sd127 - (sc16 <<< 2);
      end
      WAVE_SQUARE: begin
        y_c = (scaled > 0) ? (SQ_HI >>> shamt) : (SQ_LO >>> shamt);
      end
      default: begin
        y_c = sc16;
      end
    endcase
  end

  // echo mix, truncated toward zero
  logic signed [33:0] pa_c, pb_c, pc_c, acc;
  logic signed [17:0] quot;
  logic signed [15:0] y_e, y_o;

  always_comb begin
    pa_c = echo_line_q[TAP_A-1] * $signed({1'b0, GAIN_A});
    pb_c = echo_line_q[TAP_B-1] * $signed({1'b0, GAIN_B});
    pc_c = echo_line_q[TAP_C-1] * $signed({1'b0, GAIN_C});
    acc  = $signed({{2{y_q[15]}}, y_q, 16'b0}) + pa_q + pb_q + pc_q;
    quot = acc[33:16];
    if (acc[33] && (acc[15:0] != 16'd0)) begin
      quot = quot + 18'sd1;
    end
    y_e = echo_q ? quot[15:0] : y_q;
    y_o = (shape_q != 2'(WAVE_TRI)) ? y_e + 16'sd128 : y_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q       <= 5'd12;
      oct_q       <= 4'd4;
      shape_q     <= 2'(WAVE_SAW);
      filt_q      <= 2'(FILT_NONE);
      cutoff_q    <= 4'd0;
      echo_q      <= 1'b0;
      last_keys_q <= 12'hFFF;
      count_q     <= 4'd0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        phase_q[i] <= 32'd0;
      end
      for (int i = 0; i < ECHO_DEPTH; i++) begin
        echo_line_q[i] <= 16'sd0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_VOLUME: vol_q    <= cfg_data_i;
          CFG_OCTAVE: oct_q    <= cfg_data_i[3:0];
          CFG_SHAPE:  shape_q  <= cfg_data_i[1:0];
          CFG_FILTER: filt_q   <= cfg_data_i[1:0];
          CFG_CUTOFF: cutoff_q <= cfg_data_i[3:0];
          CFG_ECHO:   echo_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.load_mask) begin
        last_keys_q <= keys_n_i;
        count_q     <= 4'd0;
      end else if (cmd_i.scan_valid && !status_o.mask_bit && (count_q < 4'(VOICES))) begin
        count_q <= count_q + 4'd1;
      end
      s1_vld_q <= cmd_i.issue_valid;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q) begin
        phase_q[s2_idx_q] <= phase3;
      end
      if (cmd_i.echo_en && echo_q) begin
        echo_line_q[0] <= y_q;
        for (int i = 1; i < ECHO_DEPTH; i++) begin
          echo_line_q[i] <= echo_line_q[i-1];
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mask) begin
      mask_q <= keys_n_i;
    end
    if (cmd_i.scan_valid && !status_o.mask_bit && (count_q < 4'(VOICES))) begin
      voice_key_q[count_q] <= cmd_i.scan_idx;
    end
    s1_idx_q <= cmd_i.issue_idx;
    s1_key_q <= key1;
    s1_inc_q <= prod1[31:0];
    s2_idx_q <= s1_idx_q;
    if ((filt_q == 2'(FILT_LOW)) || (filt_q == 2'(FILT_HIGH))) begin
      s2_inc_q  <= {3'b000, prod2[63:35]};
      s2_filt_q <= 1'b1;
    end else begin
      s2_inc_q  <= s1_inc_q;
      s2_filt_q <= 1'b0;
    end
    s2_w_q <= w2;
    if (cmd_i.start_tick) begin
      sum_q <= 12'sd0;
    end else if (s2_vld_q) begin
      sum_q <= sum3;
    end
    if (cmd_i.shape_en) begin
      y_q <= y_c;
    end
    if (cmd_i.echo_en) begin
      pa_q <= pa_c;
      pb_q <= pb_c;
      pc_q <= pc_c;
    end
    if (cmd_i.load_out) begin
      out_q <= y_o[14:0];
    end
  end

  always_comb begin
    status_o.func         = func_i;
    status_o.keys_differ  = keys_n_i != last_keys_q;
    status_o.shape_unused = shape_q > 2'(WAVE_SQUARE);
    status_o.voice_count  = count_q;
    status_o.mask_bit     = mask_q[cmd_i.scan_idx];
    status_o.pipe_busy    = s1_vld_q || s2_vld_q;
    status_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

// File: rtl/core/ppa_ctrl.sv
module ppa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ppa_pkg::status_t  status_i,
  output ppa_pkg::cmd_t     cmd_o
);
  import ppa_pkg::*;
  `include "polyphonic_phase_accumulator_synth_core_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN,
    ST_DRAIN,
    ST_SHAPE,
    ST_ECHO,
    ST_FINAL
  } state_e;

  state_e     state_q;
  logic [3:0] scan_q;
  logic [3:0] issue_q;
  logic       accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o             = '0;
    cmd_o.scan_idx    = scan_q;
    cmd_o.issue_idx   = issue_q;
    cmd_o.load_mask   = accept && (status_i.func == FUNC_KEYS) && status_i.keys_differ;
    cmd_o.start_tick  = accept && (status_i.func == FUNC_TICK) && !status_i.shape_unused;
    cmd_o.scan_valid  = state_q == ST_SCAN;
    cmd_o.issue_valid = (state_q == ST_RUN) && (issue_q < status_i.voice_count);
    cmd_o.shape_en    = state_q == ST_SHAPE;
    cmd_o.echo_en     = state_q == ST_ECHO;
    cmd_o.load_out    = (state_q == ST_FINAL) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= 4'd0;
      issue_q <= 4'd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          scan_q  <= 4'd0;
          issue_q <= 4'd0;
          if (cmd_o.load_mask) begin
            state_q <= ST_SCAN;
          end else if (cmd_o.start_tick) begin
            state_q <= ST_RUN;
          end
        end
        ST_SCAN: begin
          if (scan_q == 4'(KEYS - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            scan_q <= scan_q + 4'd1;
          end
        end
        ST_RUN: begin
          if (cmd_o.issue_valid) begin
            issue_q <= issue_q + 4'd1;
          end else begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!status_i.pipe_busy) begin
            state_q <= ST_SHAPE;
          end
        end
        ST_SHAPE: begin
          state_q <= ST_ECHO;
        end
        ST_ECHO: begin
          state_q <= ST_FINAL;
        end
        ST_FINAL: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `PPA_ASSERT_IMP(a_issue_range, cmd_o.issue_valid, cmd_o.issue_idx < status_i.voice_count, "voice issued beyond list")
  `PPA_ASSERT_IMP(a_shape_after_drain, state_q == ST_SHAPE, !status_i.pipe_busy, "shaping with voices in flight")
  `PPA_ASSERT_IMP(a_load_when_free, cmd_o.load_out, status_i.out_free, "output register overwritten")
  `PPA_ASSERT_NXT(a_tick_runs, cmd_o.start_tick, state_q == ST_RUN && issue_q == 4'd0, "tick did not start voice walk")

endmodule

// File: bench/polyphonic_phase_accumulator_synth_core_tb.sv
module polyphonic_phase_accumulator_synth_core_tb;
  import ppa_pkg::*;

  localparam int          LIMIT_CYCLES = 600000;
  localparam int          SETTLE       = 40;
  localparam logic [1:0]  SHAPE_UNUSED = 2'd3;
  localparam logic [2:0]  IDX_SPARE_LO = 3'd6;
  localparam logic [2:0]  IDX_SPARE_HI = 3'd7;
  localparam logic [31:0] STEP_GAIN    = 32'd195225;
  localparam int          ECHO_LEN     = 45;

  typedef struct packed {
    logic        func;
    logic [11:0] keys_n;
  } synth_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  ppa_in_if  in_ch();
  ppa_out_if out_ch();

  polyphonic_phase_accumulator_synth_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // weight tables, row by cutoff, column by key
  logic [3:0] lowpass_tab [0:9][0:11] = '{
    '{10,10,10,10,10,10,10,10,10,9,8,7}, '{10,10,10,10,10,10,10,10,9,8,7,6},
    '{10,10,10,10,10,10,10,9,8,7,6,5},   '{10,10,10,10,10,10,9,8,7,6,5,4},
    '{10,10,10,10,10,9,8,7,6,5,4,3},     '{10,10,10,10,9,8,7,6,5,4,3,2},
    '{10,10,10,9,8,7,6,5,4,3,2,1},       '{10,10,9,8,7,6,5,4,3,2,1,1},
    '{10,9,8,7,6,5,4,3,2,1,1,1},         '{9,8,7,6,5,4,3,2,1,1,1,1}};
  logic [3:0] highpass_tab [0:9][0:11] = '{
    '{7,8,9,10,10,10,10,10,10,10,10,10}, '{6,7,8,9,10,10,10,10,10,10,10,10},
    '{5,6,7,8,9,10,10,10,10,10,10,10},   '{4,5,6,7,8,9,10,10,10,10,10,10},
    '{3,4,5,6,7,8,9,10,10,10,10,10},     '{2,3,4,5,6,7,8,9,10,10,10,10},
    '{1,2,3,4,5,6,7,8,9,10,10,10},       '{1,1,2,3,4,5,6,7,8,9,10,10},
    '{1,1,1,2,3,4,5,6,7,8,9,10},         '{1,1,1,1,2,3,4,5,6,7,8,9}};
  logic [8:0] pitch_tab [0:11] = '{262,277,294,311,330,349,370,392,415,440,466,494};

  // shadow of the settings and voice state
  logic [4:0]  sh_volume;
  logic [3:0]  sh_octave;
  logic [1:0]  sh_shape;
  logic [1:0]  sh_filter;
  logic [3:0]  sh_cutoff;
  logic        sh_echo;
  logic [31:0] phase_sh [0:11];
  logic [3:0]  voice_key_sh [0:11];
  int          voice_total;
  logic [11:0] prev_mask;
  logic signed [15:0] delay_sh [0:ECHO_LEN-1];

  synth_item_t        pending_items[$];
  logic signed [14:0] expected_samples[$];
  int errors = 0;
  int cycles = 0;
  logic in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cnt = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int stall_mode = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic apply_keys(input logic [11:0] mask);
    if (mask != prev_mask) begin
      voice_total = 0;
      for (int k = 0; k < KEYS; k++) begin
        if (!mask[k] && voice_total < VOICES) begin
          voice_key_sh[voice_total] = k[3:0];
          voice_total++;
        end
      end
      prev_mask = mask;
    end
  endtask

  task automatic synth_tick();
    int row, sum, vol, s, scaled, y, key;
    logic [31:0] step, inc;
    longint acc;
    if (sh_shape == SHAPE_UNUSED) return;
    row = (sh_cutoff > MAX_ROW) ? 9 : sh_cutoff;
    sum = 0;
    for (int v = 0; v < voice_total; v++) begin
      key = voice_key_sh[v];
      step = {23'd0, pitch_tab[key]};
      step = (sh_octave < 4) ? step >> (4 - sh_octave) : step << (sh_octave - 4);
      inc = step * STEP_GAIN;
      if (sh_filter == FILT_LOW) inc = (inc / 10) * lowpass_tab[row][key];
      else if (sh_filter == FILT_HIGH) inc = (inc / 10) * highpass_tab[row][key];
      phase_sh[v] = phase_sh[v] + inc;
      sum += $signed(phase_sh[v][31:24]);
    end
    vol = (sh_volume > MAX_VOL) ? 16 : sh_volume;
    s = 8 - vol / 2;
    scaled = sum >>> s;
    if (sh_shape == WAVE_SAW) y = scaled;
    else if (sh_shape == WAVE_TRI) y = (sum < 0) ? 128 + scaled * 4 : 127 - scaled * 4;
    else y = (scaled > 0) ? (127 >>> s) : (-128 >>> s);
    if (sh_echo) begin
      for (int d = ECHO_LEN - 1; d > 0; d--) delay_sh[d] = delay_sh[d-1];
      delay_sh[0] = y[15:0];
      acc = longint'(y) * 65536 + longint'(delay_sh[TAP_A]) * GAIN_A
          + longint'(delay_sh[TAP_B]) * GAIN_B + longint'(delay_sh[TAP_C]) * GAIN_C;
      y = int'(acc / 65536);
    end
    if (sh_shape != WAVE_TRI) y += 128;
    expected_samples.push_back(y[14:0]);
  endtask

  // check results, then predict accepted items
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_taken <= in_ch.valid && in_ch.ready;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample_out", out_ch.sample_out, 0);
      end else begin
        if (out_ch.sample_out !== expected_samples[0])
          report_mismatch("sample_out", out_ch.sample_out, expected_samples[0]);
        void'(expected_samples.pop_front());
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      if (in_ch.func == FUNC_KEYS) apply_keys(in_ch.keys_n);
      else synth_tick();
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout at cycle %0d", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sender: bursts and gaps
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= FUNC_TICK;
      in_ch.keys_n <= '1;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.func <= pending_items[0].func;
        in_ch.keys_n <= pending_items[0].keys_n;
        void'(pending_items.pop_front());
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
      if (hold_req && !hold_done && hold_cnt == 0) begin
        hold_cnt <= 400;
        hold_done <= 1'b1;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= (hold_cnt == 1);
      end else begin
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic write_setting(input logic [2:0] idx, input logic [4:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_VOLUME: sh_volume = data;
      CFG_OCTAVE: sh_octave = data[3:0];
      CFG_SHAPE:  sh_shape = data[1:0];
      CFG_FILTER: sh_filter = data[1:0];
      CFG_CUTOFF: sh_cutoff = data[3:0];
      CFG_ECHO:   sh_echo = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(input logic [4:0] vol, input logic [3:0] oct, input logic [1:0] shp,
                         input logic [1:0] flt, input logic [3:0] cut, input logic ech);
    write_setting(CFG_VOLUME, vol);
    write_setting(CFG_OCTAVE, {1'b0, oct});
    write_setting(CFG_SHAPE, {3'b0, shp});
    write_setting(CFG_FILTER, {3'b0, flt});
    write_setting(CFG_CUTOFF, {1'b0, cut});
    write_setting(CFG_ECHO, {4'b0, ech});
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_samples.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic queue_item(input logic f, input logic [11:0] k);
    synth_item_t it;
    it.func = f;
    it.keys_n = k;
    pending_items.push_back(it);
  endtask

  function automatic logic [11:0] prev_mask_guess();
    if (pending_items.size() == 0) return 12'hFFF;
    return pending_items[$].keys_n;
  endfunction

  // mostly ticks, with key changes mixed in
  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 3))
          0: queue_item(FUNC_KEYS, 12'($urandom_range(0, 4095)));
          1: queue_item(FUNC_KEYS, prev_mask_guess());
          2: queue_item(FUNC_KEYS, ~(12'(1) << $urandom_range(0, 11)));
          default: queue_item(FUNC_KEYS, 12'($urandom_range(0, 4095) | $urandom_range(0, 4095)));
        endcase
      end else begin
        queue_item(FUNC_TICK, 12'($urandom_range(0, 4095)));
      end
    end
  endtask

  initial begin
    sh_volume = 5'd12; sh_octave = 4'd4; sh_shape = WAVE_SAW;
    sh_filter = FILT_NONE; sh_cutoff = 4'd0; sh_echo = 1'b0;
    voice_total = 0;
    prev_mask = 12'hFFF;
    for (int i = 0; i < 12; i++) begin
      phase_sh[i] = '0;
      voice_key_sh[i] = '0;
    end
    for (int i = 0; i < ECHO_LEN; i++) delay_sh[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults, no keys, all keys, unchanged mask, single keys
    queue_item(FUNC_TICK, 12'h000);
    queue_item(FUNC_KEYS, 12'hFFF);
    queue_item(FUNC_TICK, 12'hFFF);
    queue_item(FUNC_KEYS, 12'h000);
    queue_item(FUNC_TICK, 12'h000);
    queue_item(FUNC_KEYS, 12'h000);
    queue_item(FUNC_TICK, 12'h555);
    queue_item(FUNC_KEYS, 12'hFFE);
    queue_item(FUNC_TICK, 12'hAAA);
    queue_item(FUNC_KEYS, 12'h7FF);
    queue_item(FUNC_TICK, 12'h000);
    queue_item(FUNC_KEYS, 12'h5A5);
    queue_item(FUNC_TICK, 12'hFFF);
    wait_drained();
    set_all(5'd0, 4'd0, WAVE_TRI, FILT_LOW, 4'd0, 1'b1);
    write_setting(IDX_SPARE_LO, 5'd31);
    queue_item(FUNC_KEYS, 12'h000);
    for (int i = 0; i < 5; i++) queue_item(FUNC_TICK, 12'h000);
    wait_drained();
    set_all(5'd31, 4'd15, WAVE_SQUARE, 2'd3, 4'd15, 1'b0);
    write_setting(IDX_SPARE_HI, 5'd0);
    for (int i = 0; i < 4; i++) queue_item(FUNC_TICK, 12'hFFF);
    wait_drained();
    set_all(5'd16, 4'd11, SHAPE_UNUSED, FILT_HIGH, 4'd9, 1'b1);
    queue_item(FUNC_TICK, 12'h000);
    queue_item(FUNC_KEYS, 12'hF0F);
    queue_item(FUNC_TICK, 12'hFFF);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_all(5'd12, 4'd4, WAVE_SAW, FILT_NONE, 4'd0, 1'b1);
        1: set_all(5'd16, 4'd11, WAVE_TRI, FILT_HIGH, 4'd9, 1'b1);
        2: set_all(5'd0, 4'd0, WAVE_SQUARE, FILT_LOW, 4'd15, 1'b0);
        3: set_all(5'd31, 4'd15, WAVE_SAW, FILT_HIGH, 4'd10, 1'b1);
        4: set_all(5'd8, 4'd3, SHAPE_UNUSED, 2'd3, 4'd5, 1'b1);
        default: set_all(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                         2'($urandom_range(0, 2)), 2'($urandom_range(0, 3)),
                         4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      endcase
      if (ph == 2) hold_req = 1'b1;
      queue_random(ph == 4 ? 30 : 110);
      wait_drained();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ppa_pkg.sv
rtl/core/ppa_if.sv
rtl/core/ppa_dp.sv
rtl/core/ppa_ctrl.sv
rtl/core/polyphonic_phase_accumulator_synth_core.sv
bench/polyphonic_phase_accumulator_synth_core_tb.sv
